@@ rtl/lkvc_pkg.sv @@
// Shared types and constants for the LRU key-value cache.
// No dependencies; every other file in rtl/ refers to it by scoped name.
package lkvc_pkg;

	localparam int unsigned DATA_W = 32;

	typedef logic signed [DATA_W-1:0] word_t;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	localparam word_t MISS_VALUE = '1;

	typedef struct packed {
		logic  is_put;
		word_t key;
		word_t value;
	} cmd_t;

endpackage

@@ rtl/lkvc_req_if.sv @@
// Request channel of the LRU key-value cache: valid/ready plus one operation.
// Depends on lkvc_pkg for the word type.
interface lkvc_req_if;
	logic                valid;
	logic                ready;
	logic                op;
	lkvc_pkg::word_t     lookup_key;
	lkvc_pkg::word_t     write_value;

	modport source (output valid, output op, output lookup_key, output write_value,
		input ready);
	modport sink (input valid, input op, input lookup_key, input write_value,
		output ready);
endinterface

@@ rtl/lkvc_rsp_if.sv @@
// Response channel of the LRU key-value cache: valid/ready plus one result.
// Depends on lkvc_pkg for the word type.
interface lkvc_rsp_if;
	logic                valid;
	logic                ready;
	logic                hit;
	lkvc_pkg::word_t     read_value;
	logic                evicted;
	lkvc_pkg::word_t     evicted_key;

	modport source (output valid, output hit, output read_value, output evicted,
		output evicted_key, input ready);
	modport sink (input valid, input hit, input read_value, input evicted,
		input evicted_key, output ready);
endinterface

@@ rtl/lru_key_value_cache_top.sv @@
// Top level of the fully associative LRU key-value cache.
// Depends on lkvc_pkg, lkvc_req_if, lkvc_rsp_if, lkvc_front, lkvc_fifo, lkvc_engine.
//
// Usage:
//   req carries one get (op 0) or put (op 1) with lookup_key and write_value.
//   rsp returns one result per request, in order: hit, read_value (-1 on get
//   miss, 0 for put), evicted and evicted_key (0 when nothing is evicted).
//   cfg_we/cfg_wdata write the capacity; 0 acts as 1, above ENTRIES as ENTRIES.
//   Write it only while no request is outstanding.
// Timing:
//   A request passes a holding register and a two-entry queue, then the engine
//   sweeps the key memory once, one entry per cycle over its single read port.
//   A get miss occupies the engine for that sweep alone; a hit or any put adds a
//   second rank-aging sweep. The result is then loaded into the response register,
//   raising rsp.valid, once that register is empty or being taken.
// Reset:
//   The cache empties, capacity returns to 16; stored keys and values are not cleared.
// Stall:
//   A held response keeps its register; the engine still works on the next
//   queued item and waits only to hand its result over, while the queue and
//   holding register keep taking up to three further transfers.
module lru_key_value_cache_top #(
	parameter int unsigned ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	lkvc_req_if.sink    req,
	lkvc_rsp_if.source  rsp,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata
);
	logic [4:0]     active_q;
	lkvc_pkg::cmd_t front_cmd;
	logic           front_valid;
	logic           front_ready;
	lkvc_pkg::cmd_t queue_cmd;
	logic           queue_valid;
	logic           queue_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 5'd16;
		end else if (cfg_we) begin
			active_q <= cfg_wdata;
		end
	end

	lkvc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (front_cmd),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready)
	);

	lkvc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cmd   (front_cmd),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_cmd    (queue_cmd),
		.pop_valid  (queue_valid),
		.pop        (queue_pop)
	);

	lkvc_engine #(
		.ENTRIES (ENTRIES)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.active    (active_q),
		.cmd       (queue_cmd),
		.cmd_valid (queue_valid),
		.cmd_pop   (queue_pop),
		.rsp       (rsp)
	);
endmodule

@@ rtl/lkvc_front.sv @@
// Front stage: takes request transfers into a holding register and decodes the operation.
// Depends on lkvc_pkg and lkvc_req_if.
module lkvc_front (
	input  logic            clk,
	input  logic            arst_n,
	lkvc_req_if.sink        req,
	output lkvc_pkg::cmd_t  cmd,
	output logic            cmd_valid,
	input  logic            cmd_ready
);
	logic           hold_q;
	lkvc_pkg::cmd_t cmd_q;

	assign req.ready = !hold_q || cmd_ready;
	assign cmd_valid = hold_q;
	assign cmd       = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
		end else if (req.valid && req.ready) begin
			hold_q <= 1'b1;
		end else if (cmd_ready) begin
			hold_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_q.is_put <= (req.op == lkvc_pkg::OP_PUT);
			cmd_q.key    <= req.lookup_key;
			cmd_q.value  <= req.write_value;
		end
	end
endmodule

@@ rtl/lkvc_fifo.sv @@
// Two-entry command queue between the front stage and the lookup engine.
// Depends on lkvc_pkg for the command type.
module lkvc_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  lkvc_pkg::cmd_t  push_cmd,
	input  logic            push_valid,
	output logic            push_ready,
	output lkvc_pkg::cmd_t  pop_cmd,
	output logic            pop_valid,
	input  logic            pop
);
	localparam int unsigned DEPTH = 2;
	localparam int unsigned AW    = $clog2(DEPTH);

	lkvc_pkg::cmd_t   mem [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != (AW+1)'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = mem[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_cmd;
		end
	end
endmodule

@@ rtl/lkvc_engine.sv @@
// Lookup engine: sweeps the key/rank memories to find hit, free slot and LRU victim,
// applies the op, re-sweeps on hit or put to age ranks, and registers the response.
// Depends on lkvc_pkg and lkvc_rsp_if.
module lkvc_engine #(
	parameter int unsigned ENTRIES = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [4:0]      active,
	input  lkvc_pkg::cmd_t  cmd,
	input  logic            cmd_valid,
	output logic            cmd_pop,
	lkvc_rsp_if.source      rsp
);
	localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CW = $clog2(ENTRIES + 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_UPD    = 3'd3;
	localparam logic [2:0] S_RESULT = 3'd4;

	logic [2:0]             state_q;
	lkvc_pkg::cmd_t         cmd_q;
	logic [CW-1:0]          cnt_q;
	logic [CW-1:0]          occ_q;
	logic [ENTRIES-1:0]     valid_q;

	lkvc_pkg::word_t        key_mem  [ENTRIES];
	lkvc_pkg::word_t        val_mem  [ENTRIES];
	logic [IW-1:0]          rank_mem [ENTRIES];

	logic                   rd_s1;
	logic [IW-1:0]          idx_s1;
	lkvc_pkg::word_t        key_s1;
	lkvc_pkg::word_t        val_s1;
	logic [IW-1:0]          rank_s1;

	logic                   match_found_q;
	logic [IW-1:0]          match_idx_q;
	logic [IW-1:0]          match_rank_q;
	lkvc_pkg::word_t        match_val_q;
	logic                   free_found_q;
	logic [IW-1:0]          free_idx_q;
	logic                   vic_found_q;
	logic [IW-1:0]          vic_idx_q;
	logic [IW-1:0]          vic_rank_q;
	lkvc_pkg::word_t        vic_key_q;

	logic [IW-1:0]          target_q;
	logic [CW-1:0]          thresh_q;
	logic                   res_hit_q;
	lkvc_pkg::word_t        res_val_q;
	logic                   res_ev_q;
	lkvc_pkg::word_t        res_evkey_q;

	logic                   out_valid_q;
	logic                   out_hit_q;
	lkvc_pkg::word_t        out_val_q;
	logic                   out_ev_q;
	lkvc_pkg::word_t        out_evkey_q;

	logic [CW-1:0]          cap;
	logic [IW-1:0]          rd_addr;
	logic                   sweeping;
	logic                   do_insert;
	logic                   do_evict;
	logic [IW-1:0]          wr_idx;
	logic                   key_we;
	logic                   val_we;
	logic [IW-1:0]          rank_wdata;
	logic                   load_out;
	logic                   scan_hit;

	always_comb begin
		if (active == 5'd0) begin
			cap = CW'(1);
		end else if (32'(active) > ENTRIES) begin
			cap = CW'(ENTRIES);
		end else begin
			cap = CW'(active);
		end
	end

	assign rd_addr   = cnt_q[IW-1:0];
	assign sweeping  = (state_q == S_SCAN || state_q == S_UPD) && (cnt_q != CW'(ENTRIES));
	assign cmd_pop   = (state_q == S_IDLE) && cmd_valid;
	assign load_out  = (state_q == S_RESULT) && (!out_valid_q || rsp.ready);
	assign scan_hit  = valid_q[idx_s1] && (key_s1 == cmd_q.key);

	assign do_insert = cmd_q.is_put && !match_found_q && (occ_q < cap);
	assign do_evict  = cmd_q.is_put && !match_found_q && !(occ_q < cap);
	assign wr_idx    = match_found_q ? match_idx_q : (do_insert ? free_idx_q : vic_idx_q);
	assign key_we    = (state_q == S_DECIDE) && (do_insert || do_evict);
	assign val_we    = (state_q == S_DECIDE) && cmd_q.is_put;

	always_comb begin
		if (idx_s1 == target_q) begin
			rank_wdata = '0;
		end else if (valid_q[idx_s1] && (CW'(rank_s1) < thresh_q)) begin
			rank_wdata = rank_s1 + 1'b1;
		end else begin
			rank_wdata = rank_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[wr_idx] <= cmd_q.key;
		end
		if (val_we) begin
			val_mem[wr_idx] <= cmd_q.value;
		end
		if (rd_s1 && state_q == S_UPD) begin
			rank_mem[idx_s1] <= rank_wdata;
		end
		key_s1  <= key_mem[rd_addr];
		val_s1  <= val_mem[rd_addr];
		rank_s1 <= rank_mem[rd_addr];
		idx_s1  <= rd_addr;
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (rd_s1 && state_q == S_SCAN) begin
			if (scan_hit && !match_found_q) begin
				match_idx_q  <= idx_s1;
				match_rank_q <= rank_s1;
				match_val_q  <= val_s1;
			end
			if (!valid_q[idx_s1] && !free_found_q) begin
				free_idx_q <= idx_s1;
			end
			if (valid_q[idx_s1] && (!vic_found_q || rank_s1 > vic_rank_q)) begin
				vic_idx_q  <= idx_s1;
				vic_rank_q <= rank_s1;
				vic_key_q  <= key_s1;
			end
		end
		if (state_q == S_DECIDE) begin
			res_hit_q   <= match_found_q;
			res_ev_q    <= do_evict;
			res_evkey_q <= do_evict ? vic_key_q : '0;
			if (match_found_q) begin
				res_val_q <= cmd_q.is_put ? '0 : match_val_q;
			end else begin
				res_val_q <= cmd_q.is_put ? '0 : lkvc_pkg::MISS_VALUE;
			end
			target_q <= wr_idx;
			if (match_found_q) begin
				thresh_q <= CW'(match_rank_q);
			end else if (do_insert) begin
				thresh_q <= CW'(ENTRIES);
			end else begin
				thresh_q <= CW'(vic_rank_q);
			end
		end
		if (load_out) begin
			out_hit_q   <= res_hit_q;
			out_val_q   <= res_val_q;
			out_ev_q    <= res_ev_q;
			out_evkey_q <= res_evkey_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cnt_q         <= '0;
			occ_q         <= '0;
			valid_q       <= '0;
			rd_s1         <= 1'b0;
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			vic_found_q   <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			rd_s1 <= sweeping;
			if (sweeping) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (rd_s1 && state_q == S_SCAN) begin
				if (scan_hit) begin
					match_found_q <= 1'b1;
				end
				if (!valid_q[idx_s1]) begin
					free_found_q <= 1'b1;
				end else begin
					vic_found_q <= 1'b1;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cnt_q         <= '0;
						match_found_q <= 1'b0;
						free_found_q  <= 1'b0;
						vic_found_q   <= 1'b0;
						state_q       <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (!sweeping) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					cnt_q <= '0;
					if (do_insert) begin
						valid_q[free_idx_q] <= 1'b1;
						occ_q               <= occ_q + 1'b1;
					end
					state_q <= (match_found_q || cmd_q.is_put) ? S_UPD : S_RESULT;
				end
				S_UPD: begin
					if (!sweeping) begin
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.hit         = out_hit_q;
	assign rsp.read_value  = out_val_q;
	assign rsp.evicted     = out_ev_q;
	assign rsp.evicted_key = out_evkey_q;

	a_occ_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		32'($countones(valid_q)) == 32'(occ_q))
		else $error("occupancy differs from number of valid entries");

	a_insert_has_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE && do_insert) |-> free_found_q)
		else $error("insert without a free slot");

	a_evict_has_victim: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE && do_evict) |-> vic_found_q)
		else $error("eviction without a victim");

	a_evict_not_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_hit_q && out_ev_q))
		else $error("response flags both hit and eviction");

	a_occ_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE && do_insert) |=> (occ_q <= CW'(ENTRIES)))
		else $error("occupancy above entry count");
endmodule

@@ verif/lru_key_value_cache_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for lru_key_value_cache_top: drives gets and puts, predicts each reply
// with its own LRU model and compares every reply field in order.
// Depends on lkvc_pkg, lkvc_req_if, lkvc_rsp_if and the cache RTL.
module lru_key_value_cache_top_tb;

	localparam int unsigned SLOTS = 16;
	localparam int unsigned LONG_HOLD = 200;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam lkvc_pkg::word_t KEY_MIN = lkvc_pkg::word_t'(32'h8000_0000);
	localparam lkvc_pkg::word_t KEY_MAX = lkvc_pkg::word_t'(32'h7FFF_FFFF);

	typedef struct packed {
		logic            hit;
		lkvc_pkg::word_t read_value;
		logic            evicted;
		lkvc_pkg::word_t evicted_key;
	} access_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [4:0] cfg_wdata;
	logic hold_request;

	lkvc_req_if req_ch();
	lkvc_rsp_if rsp_ch();

	lru_key_value_cache_top #(.ENTRIES(SLOTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	lkvc_pkg::word_t slot_key [SLOTS];
	lkvc_pkg::word_t slot_val [SLOTS];
	bit slot_used [SLOTS];
	int unsigned slot_age [SLOTS];
	int unsigned fill_count;
	logic [4:0] cap_reg;

	access_result_t expected_replies [$];
	lkvc_pkg::word_t key_pool [$];
	int unsigned idle_pct;
	int unsigned mismatch_count;
	int unsigned cycle_count = 0;

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic int unsigned capacity_limit();
		if (cap_reg == 0)
			return 1;
		if (cap_reg > SLOTS)
			return SLOTS;
		return cap_reg;
	endfunction

	function automatic void refresh_age(int s);
		int unsigned old_age;
		old_age = slot_age[s];
		for (int i = 0; i < SLOTS; i++)
			if (i != s && slot_used[i] && slot_age[i] < old_age)
				slot_age[i]++;
		slot_age[s] = 0;
	endfunction

	function automatic access_result_t lru_apply(logic op_code, lkvc_pkg::word_t key,
		lkvc_pkg::word_t value);
		access_result_t r;
		int hit_slot;
		int free_slot;
		int victim;
		r = '0;
		hit_slot = -1;
		free_slot = -1;
		victim = -1;
		for (int i = 0; i < SLOTS; i++)
			if (hit_slot < 0 && slot_used[i] && slot_key[i] == key)
				hit_slot = i;
		if (hit_slot >= 0) begin
			r.hit = 1'b1;
			if (op_code == lkvc_pkg::OP_PUT)
				slot_val[hit_slot] = value;
			else
				r.read_value = slot_val[hit_slot];
			refresh_age(hit_slot);
		end else if (op_code == lkvc_pkg::OP_GET) begin
			r.read_value = lkvc_pkg::MISS_VALUE;
		end else if (fill_count < capacity_limit()) begin
			for (int i = 0; i < SLOTS; i++)
				if (free_slot < 0 && !slot_used[i])
					free_slot = i;
			for (int i = 0; i < SLOTS; i++)
				if (slot_used[i])
					slot_age[i]++;
			slot_used[free_slot] = 1'b1;
			slot_key[free_slot] = key;
			slot_val[free_slot] = value;
			slot_age[free_slot] = 0;
			fill_count++;
		end else begin
			for (int i = 0; i < SLOTS; i++)
				if (slot_used[i] && (victim < 0 || slot_age[i] > slot_age[victim]))
					victim = i;
			r.evicted = 1'b1;
			r.evicted_key = slot_key[victim];
			slot_key[victim] = key;
			slot_val[victim] = value;
			refresh_age(victim);
		end
		return r;
	endfunction

	task automatic report_field(string field, lkvc_pkg::word_t want, lkvc_pkg::word_t got);
		if (mismatch_count < 10)
			$display("%0t: %s mismatch: expected %h, got %h", $realtime, field, want, got);
		mismatch_count++;
	endtask

	task automatic check_reply();
		access_result_t want;
		if (expected_replies.size() == 0) begin
			if (mismatch_count < 10)
				$display("%0t: reply with no request outstanding", $realtime);
			mismatch_count++;
		end else begin
			want = expected_replies.pop_front();
			if (rsp_ch.hit !== want.hit)
				report_field("hit", lkvc_pkg::word_t'(want.hit),
					lkvc_pkg::word_t'(rsp_ch.hit));
			if (rsp_ch.read_value !== want.read_value)
				report_field("read_value", want.read_value, rsp_ch.read_value);
			if (rsp_ch.evicted !== want.evicted)
				report_field("evicted", lkvc_pkg::word_t'(want.evicted),
					lkvc_pkg::word_t'(rsp_ch.evicted));
			if (rsp_ch.evicted_key !== want.evicted_key)
				report_field("evicted_key", want.evicted_key, rsp_ch.evicted_key);
		end
	endtask

	always @(posedge clk)
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			check_reply();

	initial begin : rsp_pacing
		int unsigned quiet_left;
		quiet_left = 0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request <= 1'b0;
				quiet_left = LONG_HOLD - 1;
				rsp_ch.ready <= 1'b0;
			end else if (quiet_left != 0) begin
				quiet_left--;
				rsp_ch.ready <= 1'b0;
			end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 3) begin
				quiet_left = $urandom_range(0, 8);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	task automatic issue_request(input logic op_code, input lkvc_pkg::word_t key,
		input lkvc_pkg::word_t value);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= op_code;
		req_ch.lookup_key <= key;
		req_ch.write_value <= value;
		do @(posedge clk); while (!req_ch.ready);
		expected_replies.push_back(lru_apply(op_code, key, value));
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		while (expected_replies.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_capacity(input logic [4:0] cap);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we <= 1'b0;
		cap_reg = cap;
	endtask

	function automatic void build_key_pool(int unsigned n);
		key_pool.delete();
		repeat (n)
			key_pool.push_back(lkvc_pkg::word_t'($urandom));
		if ($urandom_range(0, 3) == 0) begin
			key_pool.push_back(KEY_MIN);
			key_pool.push_back(KEY_MAX);
		end
	endfunction

	function automatic lkvc_pkg::word_t pick_key();
		if ($urandom_range(0, 4) == 0)
			return lkvc_pkg::word_t'($urandom);
		return key_pool[$urandom_range(0, key_pool.size() - 1)];
	endfunction

	function automatic int unsigned pick_idle();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 10;
			2: return 30;
			default: return 60;
		endcase
	endfunction

	task automatic test_basic_ops();
		idle_pct = 20;
		issue_request(lkvc_pkg::OP_GET, KEY_MIN, lkvc_pkg::word_t'($urandom));
		issue_request(lkvc_pkg::OP_PUT, KEY_MIN, KEY_MAX);
		issue_request(lkvc_pkg::OP_PUT, KEY_MAX, KEY_MIN);
		issue_request(lkvc_pkg::OP_PUT, '0, '0);
		issue_request(lkvc_pkg::OP_PUT, '1, '1);
		issue_request(lkvc_pkg::OP_GET, KEY_MIN, lkvc_pkg::word_t'($urandom));
		issue_request(lkvc_pkg::OP_PUT, '0, lkvc_pkg::word_t'(32'h1234_5678));
		issue_request(lkvc_pkg::OP_GET, '0, lkvc_pkg::word_t'($urandom));
		issue_request(lkvc_pkg::OP_GET, '1, '0);
		issue_request(lkvc_pkg::OP_GET, lkvc_pkg::word_t'(32'h0000_0005), '1);
	endtask

	task automatic test_evict_at_capacity();
		set_capacity(5'd4);
		issue_request(lkvc_pkg::OP_PUT, lkvc_pkg::word_t'(32'h5555_5555),
			lkvc_pkg::word_t'(32'hAAAA_AAAA));
		issue_request(lkvc_pkg::OP_PUT, lkvc_pkg::word_t'(32'hAAAA_AAAA),
			lkvc_pkg::word_t'(32'h5555_5555));
		issue_request(lkvc_pkg::OP_GET, KEY_MAX, '0);
		issue_request(lkvc_pkg::OP_GET, '0, '0);
		issue_request(lkvc_pkg::OP_PUT, lkvc_pkg::word_t'(32'h0F0F_0F0F),
			lkvc_pkg::word_t'(32'hF0F0_F0F0));
	endtask

	task automatic test_capacity_shrink();
		set_capacity(5'd16);
		for (int i = 1; i <= 4; i++)
			issue_request(lkvc_pkg::OP_PUT, lkvc_pkg::word_t'(32'h0100_0000 * i),
				lkvc_pkg::word_t'($urandom));
		set_capacity(5'd2);
		issue_request(lkvc_pkg::OP_PUT, lkvc_pkg::word_t'(32'h0BAD_0001),
			lkvc_pkg::word_t'($urandom));
		issue_request(lkvc_pkg::OP_GET, lkvc_pkg::word_t'(32'h0100_0000), '0);
		issue_request(lkvc_pkg::OP_PUT, lkvc_pkg::word_t'(32'h0BAD_0002),
			lkvc_pkg::word_t'($urandom));
	endtask

	task automatic test_capacity_bounds();
		set_capacity(5'd0);
		issue_request(lkvc_pkg::OP_PUT, lkvc_pkg::word_t'(32'h0C0C_0001),
			lkvc_pkg::word_t'($urandom));
		issue_request(lkvc_pkg::OP_PUT, lkvc_pkg::word_t'(32'h0C0C_0002),
			lkvc_pkg::word_t'($urandom));
		set_capacity(5'd31);
		issue_request(lkvc_pkg::OP_PUT, lkvc_pkg::word_t'(32'h0C0C_0003),
			lkvc_pkg::word_t'($urandom));
		issue_request(lkvc_pkg::OP_PUT, lkvc_pkg::word_t'(32'h0C0C_0004),
			lkvc_pkg::word_t'($urandom));
	endtask

	task automatic test_output_hold();
		set_capacity(5'd8);
		idle_pct = 0;
		build_key_pool(10);
		hold_request <= 1'b1;
		repeat (12)
			issue_request($urandom_range(0, 1) ? lkvc_pkg::OP_PUT : lkvc_pkg::OP_GET,
				pick_key(), lkvc_pkg::word_t'($urandom));
	endtask

	task automatic run_random_phase(input logic [4:0] cap, input int unsigned count);
		set_capacity(cap);
		build_key_pool(capacity_limit() + 3);
		for (int n = 0; n < count; n++) begin
			if (n % 20 == 0)
				idle_pct = pick_idle();
			issue_request(($urandom_range(0, 99) < 55) ? lkvc_pkg::OP_PUT : lkvc_pkg::OP_GET,
				pick_key(), lkvc_pkg::word_t'($urandom));
		end
	endtask

	task automatic test_random_traffic();
		run_random_phase(5'd16, 50);
		run_random_phase(5'd1, 50);
		run_random_phase(5'd3, 50);
		run_random_phase(5'd31, 50);
		run_random_phase(5'd0, 50);
		run_random_phase(5'd8, 50);
		run_random_phase(5'd17, 50);
		run_random_phase(5'($urandom_range(1, 16)), 50);
	endtask

	task automatic test_quiet_tail();
		set_capacity(5'($urandom_range(2, 16)));
		idle_pct = 0;
		build_key_pool(capacity_limit() + 3);
		repeat (60)
			issue_request(($urandom_range(0, 99) < 55) ? lkvc_pkg::OP_PUT : lkvc_pkg::OP_GET,
				pick_key(), lkvc_pkg::word_t'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		hold_request = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.op = lkvc_pkg::OP_GET;
		req_ch.lookup_key = '0;
		req_ch.write_value = '0;
		idle_pct = 0;
		mismatch_count = 0;
		fill_count = 0;
		cap_reg = 5'd16;
		for (int i = 0; i < SLOTS; i++) begin
			slot_used[i] = 1'b0;
			slot_age[i] = 0;
			slot_key[i] = '0;
			slot_val[i] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_ops();
		test_evict_at_capacity();
		test_capacity_shrink();
		test_capacity_bounds();
		test_output_hold();
		test_random_traffic();
		test_quiet_tail();

		settle();
		repeat (2 * SLOTS + 8) @(posedge clk);
		if (mismatch_count == 0 && expected_replies.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
